>>> rtl/core/plob_pkg.sv
`timescale 1ns / 1ps
package plob_pkg;

    localparam int ID_W    = 48;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int TOT_W   = 48;
    localparam int CNT_W   = 11;
    localparam int USED_W  = 7;
    localparam int LIVE_W  = 11;

    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_CANCEL = 2'd1,
        K_TRADE  = 2'd2,
        K_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOID  = 2'd1,
        ST_OFULL = 2'd2,
        ST_LFULL = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              op;
        logic [ID_W-1:0]    main_id;
        logic [ID_W-1:0]    other_id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_req;

    typedef struct packed {
        logic               live;
        logic [ID_W-1:0]    id;
        logic               sell;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   rem;
    } t_slot;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [TOT_W-1:0]   total;
        logic [CNT_W-1:0]   count;
    } t_lvl;

    typedef struct packed {
        t_status            status;
        logic               bid_valid;
        logic [PRICE_W-1:0] bid_px;
        logic [TOT_W-1:0]   bid_volume;
        logic [CNT_W-1:0]   bid_orders;
        logic               ask_valid;
        logic [PRICE_W-1:0] ask_px;
        logic [TOT_W-1:0]   ask_volume;
        logic [CNT_W-1:0]   ask_orders;
        logic [USED_W-1:0]  bid_used;
        logic [USED_W-1:0]  ask_used;
        logic [LIVE_W-1:0]  live;
    } t_res;

endpackage

>>> rtl/core/plob_ram.sv
`timescale 1ns / 1ps
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/plob_front.sv
`timescale 1ns / 1ps
module plob_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [47:0]          i_order_id,
    input  logic [47:0]          i_other_order_id,
    input  logic                 i_side,
    input  logic [31:0]          i_price_ticks,
    input  logic [31:0]          i_quantity,
    output logic                 o_req_valid,
    input  logic                 i_req_pop,
    output plob_pkg::t_req       o_req
);
    import plob_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_req       cls;
    logic       push;
    logic       pop;

    // decode the request kind
    always_comb begin
        cls          = '0;
        cls.main_id  = i_order_id;
        cls.side     = i_side;
        cls.price    = i_price_ticks;
        cls.qty      = i_quantity;
        case (i_kind)
            K_ADD: cls.op = K_ADD;
            K_CANCEL: cls.op = K_CANCEL;
            K_TRADE: begin
                cls.op       = K_TRADE;
                cls.other_id = i_other_order_id;
            end
            default: cls.op = K_NOP;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2) || !i_en;
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != 2'd0);
    assign pop         = o_req_valid && i_req_pop;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> rtl/core/plob_back.sv
`timescale 1ns / 1ps
module plob_back #(
    parameter int MAX_ORDERS = 1024,
    parameter int LEVEL_CAP  = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    output logic           o_ready,
    input  logic           i_req_valid,
    output logic           o_req_pop,
    input  plob_pkg::t_req i_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output plob_pkg::t_res o_res
);
    import plob_pkg::*;

    localparam int SW  = $clog2(MAX_ORDERS);
    localparam int SUW = $clog2(MAX_ORDERS + 1);
    localparam int LW  = $clog2(LEVEL_CAP);
    localparam int LUW = $clog2(LEVEL_CAP + 1);
    localparam int SLOT_W = $bits(t_slot);
    localparam int LVL_W  = $bits(t_lvl);

    typedef enum logic [12:0] {
        S_CLR    = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_SSCAN  = 13'b0000000000100,
        S_LSCAN  = 13'b0000000001000,
        S_LACT   = 13'b0000000010000,
        S_SHR_RD = 13'b0000000100000,
        S_SHR_WR = 13'b0000001000000,
        S_INS    = 13'b0000010000000,
        S_SHL_RD = 13'b0000100000000,
        S_SHL_WR = 13'b0001000000000,
        S_SWR    = 13'b0010000000000,
        S_TOP    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state             r_state;
    t_kind              r_op;
    logic [ID_W-1:0]    r_id;
    logic [ID_W-1:0]    r_other;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic               r_add_side;
    t_status            r_status;
    logic               r_phase;
    logic               r_find_free;
    logic [SUW-1:0]     r_sidx;
    logic [SW-1:0]      r_pidx;
    logic               r_pv;
    logic [SW-1:0]      r_slot_idx;
    logic               r_s_sell;
    logic [PRICE_W-1:0] r_s_price;
    logic [QTY_W-1:0]   r_s_rem;
    logic               r_side;
    logic [PRICE_W-1:0] r_lp;
    logic [LUW-1:0]     r_lidx;
    logic [LW-1:0]      r_lpidx;
    logic               r_lv;
    logic [LUW-1:0]     r_lpos;
    logic               r_lfound;
    t_lvl               r_l;
    logic [LW-1:0]      r_k;
    logic [LUW-1:0]     r_bid_used;
    logic [LUW-1:0]     r_ask_used;
    logic [SUW-1:0]     r_live;
    logic               r_out_valid;
    t_res               r_res;

    logic               s_we;
    logic [SW-1:0]      s_waddr;
    t_slot              s_wdata;
    logic [SW-1:0]      s_raddr;
    logic [SLOT_W-1:0]  s_q;
    logic               l_we;
    logic [LW-1:0]      l_waddr;
    t_lvl               l_wdata;
    logic [LW-1:0]      l_raddr;
    logic [LVL_W-1:0]   bid_q;
    logic [LVL_W-1:0]   ask_q;

    t_slot              sq;
    t_lvl               lq;
    t_lvl               bq;
    t_lvl               aq;
    logic [LUW-1:0]     n_used;
    logic               ahead;
    logic               smatch;
    logic [TOT_W-1:0]   red_qty;
    logic               drop;
    logic [TOT_W-1:0]   red_total;
    logic [CNT_W-1:0]   red_count;
    logic [TOT_W:0]     add_sum;
    logic [TOT_W-1:0]   add_total;
    logic [QTY_W-1:0]   new_rem;

    assign sq     = t_slot'(s_q);
    assign lq     = t_lvl'(r_side ? ask_q : bid_q);
    assign bq     = t_lvl'(bid_q);
    assign aq     = t_lvl'(ask_q);
    assign n_used = r_side ? r_ask_used : r_bid_used;
    assign ahead  = r_side ? (lq.price < r_lp) : (lq.price > r_lp);
    assign smatch = r_find_free ? !sq.live : (sq.live && (sq.id == r_id));
    assign red_qty = (r_op == K_CANCEL) ? TOT_W'(r_s_rem) : TOT_W'(r_qty);
    assign drop    = (r_op == K_CANCEL) ? 1'b1 : (r_s_rem <= r_qty);
    assign red_total = (r_l.total > red_qty) ? (r_l.total - red_qty) : '0;
    assign red_count = (drop && (r_l.count != '0)) ? (r_l.count - CNT_W'(1)) : r_l.count;
    assign add_sum   = {1'b0, r_l.total} + (TOT_W + 1)'(r_qty);
    assign add_total = add_sum[TOT_W] ? TOT_MAX : add_sum[TOT_W-1:0];
    assign new_rem   = (r_s_rem > r_qty) ? (r_s_rem - r_qty) : '0;

    assign o_ready     = (r_state != S_CLR);
    assign o_req_pop   = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_slot_idx;
        s_wdata = '0;
        s_raddr = r_sidx[SW-1:0];
        l_we    = 1'b0;
        l_waddr = r_lpos[LW-1:0];
        l_wdata = '0;
        l_raddr = r_lidx[LW-1:0];
        case (r_state)
            S_CLR: begin
                s_we    = 1'b1;
                s_waddr = r_sidx[SW-1:0];
            end
            S_LACT: begin
                if (r_lfound && (r_op == K_ADD)) begin
                    l_we    = 1'b1;
                    l_wdata = '{price: r_lp, total: add_total,
                                count: r_l.count + CNT_W'(1)};
                end else if (r_lfound && (red_total != '0)) begin
                    l_we    = 1'b1;
                    l_wdata = '{price: r_lp, total: red_total, count: red_count};
                end
            end
            S_SHR_RD: l_raddr = r_k - LW'(1);
            S_SHR_WR: begin
                l_we    = 1'b1;
                l_waddr = r_k;
                l_wdata = lq;
            end
            S_INS: begin
                l_we    = 1'b1;
                l_wdata = '{price: r_lp, total: TOT_W'(r_qty), count: CNT_W'(1)};
            end
            S_SHL_RD: l_raddr = r_k + LW'(1);
            S_SHL_WR: begin
                l_we    = 1'b1;
                l_waddr = r_k;
                l_wdata = lq;
            end
            S_SWR: begin
                s_we = 1'b1;
                case (r_op)
                    K_ADD: s_wdata = '{live: 1'b1, id: r_id, sell: r_add_side,
                                       price: r_price, rem: r_qty};
                    K_CANCEL: s_wdata = '{live: 1'b0, id: r_id, sell: r_s_sell,
                                          price: r_s_price, rem: r_s_rem};
                    default: s_wdata = '{live: (new_rem != '0), id: r_id,
                                         sell: r_s_sell, price: r_s_price, rem: new_rem};
                endcase
            end
            S_TOP, S_OUT: l_raddr = '0;
            default: ;
        endcase
    end

    plob_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ORDERS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_q)
    );

    plob_ram #(.WIDTH(LVL_W), .DEPTH(LEVEL_CAP)) u_bids (
        .i_clk   (i_clk),
        .i_we    (l_we && !r_side),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (bid_q)
    );

    plob_ram #(.WIDTH(LVL_W), .DEPTH(LEVEL_CAP)) u_asks (
        .i_clk   (i_clk),
        .i_we    (l_we && r_side),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (ask_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_sidx      <= '0;
            r_bid_used  <= '0;
            r_ask_used  <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_sidx <= r_sidx + SUW'(1);
                    if (r_sidx == SUW'(MAX_ORDERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op        <= i_req.op;
                        r_id        <= i_req.main_id;
                        r_other     <= i_req.other_id;
                        r_price     <= i_req.price;
                        r_qty       <= i_req.qty;
                        r_add_side  <= i_req.side;
                        r_status    <= ST_OK;
                        r_phase     <= 1'b0;
                        r_find_free <= (i_req.op == K_ADD);
                        r_sidx      <= '0;
                        r_pv        <= 1'b0;
                        r_state     <= (i_req.op == K_NOP) ? S_TOP : S_SSCAN;
                    end
                end
                S_SSCAN: begin
                    if (r_pv && smatch) begin
                        r_slot_idx <= r_pidx;
                        r_s_sell   <= sq.sell;
                        r_s_price  <= sq.price;
                        r_s_rem    <= sq.rem;
                        r_side     <= (r_op == K_ADD) ? r_add_side : sq.sell;
                        r_lp       <= (r_op == K_ADD) ? r_price : sq.price;
                        r_lidx     <= '0;
                        r_lv       <= 1'b0;
                        r_state    <= S_LSCAN;
                    end else if (r_pv && (r_pidx == SW'(MAX_ORDERS - 1))) begin
                        case (r_op)
                            K_ADD: begin
                                r_status <= ST_OFULL;
                                r_state  <= S_TOP;
                            end
                            K_TRADE: begin
                                r_status <= ST_NOID;
                                if (!r_phase) begin
                                    r_phase <= 1'b1;
                                    r_id    <= r_other;
                                    r_sidx  <= '0;
                                    r_pv    <= 1'b0;
                                end else begin
                                    r_state <= S_TOP;
                                end
                            end
                            default: begin
                                r_status <= ST_NOID;
                                r_state  <= S_TOP;
                            end
                        endcase
                    end else begin
                        r_pv   <= (r_sidx < SUW'(MAX_ORDERS));
                        r_pidx <= r_sidx[SW-1:0];
                        if (r_sidx < SUW'(MAX_ORDERS)) begin
                            r_sidx <= r_sidx + SUW'(1);
                        end
                    end
                end
                S_LSCAN: begin
                    if (r_lv && !ahead) begin
                        r_lpos   <= LUW'(r_lpidx);
                        r_lfound <= (lq.price == r_lp);
                        r_l      <= lq;
                        r_state  <= S_LACT;
                    end else if ((r_lv && ((LUW'(r_lpidx) + LUW'(1)) == n_used)) ||
                                 (!r_lv && (r_lidx >= n_used))) begin
                        r_lpos   <= n_used;
                        r_lfound <= 1'b0;
                        r_state  <= S_LACT;
                    end else begin
                        r_lv    <= (r_lidx < n_used);
                        r_lpidx <= r_lidx[LW-1:0];
                        if (r_lidx < n_used) begin
                            r_lidx <= r_lidx + LUW'(1);
                        end
                    end
                end
                S_LACT: begin
                    if (r_op == K_ADD) begin
                        if (r_lfound) begin
                            r_state <= S_SWR;
                        end else if (n_used >= LUW'(LEVEL_CAP)) begin
                            r_status <= ST_LFULL;
                            r_state  <= S_TOP;
                        end else begin
                            r_k     <= n_used[LW-1:0];
                            r_state <= (n_used > r_lpos) ? S_SHR_RD : S_INS;
                        end
                    end else if (!r_lfound || (red_total != '0)) begin
                        r_state <= S_SWR;
                    end else begin
                        r_k <= r_lpos[LW-1:0];
                        if ((r_lpos + LUW'(1)) < n_used) begin
                            r_state <= S_SHL_RD;
                        end else begin
                            if (r_side) r_ask_used <= r_ask_used - LUW'(1);
                            else        r_bid_used <= r_bid_used - LUW'(1);
                            r_state <= S_SWR;
                        end
                    end
                end
                S_SHR_RD: r_state <= S_SHR_WR;
                S_SHR_WR: begin
                    r_k <= r_k - LW'(1);
                    r_state <= (LUW'(r_k - LW'(1)) == r_lpos) ? S_INS : S_SHR_RD;
                end
                S_INS: begin
                    if (r_side) r_ask_used <= r_ask_used + LUW'(1);
                    else        r_bid_used <= r_bid_used + LUW'(1);
                    r_state <= S_SWR;
                end
                S_SHL_RD: r_state <= S_SHL_WR;
                S_SHL_WR: begin
                    r_k <= r_k + LW'(1);
                    if ((LUW'(r_k) + LUW'(2)) < n_used) begin
                        r_state <= S_SHL_RD;
                    end else begin
                        if (r_side) r_ask_used <= r_ask_used - LUW'(1);
                        else        r_bid_used <= r_bid_used - LUW'(1);
                        r_state <= S_SWR;
                    end
                end
                S_SWR: begin
                    case (r_op)
                        K_ADD: r_live <= r_live + SUW'(1);
                        K_CANCEL: begin
                            if (r_live != '0) r_live <= r_live - SUW'(1);
                        end
                        default: begin
                            if ((new_rem == '0) && (r_live != '0)) begin
                                r_live <= r_live - SUW'(1);
                            end
                        end
                    endcase
                    if ((r_op == K_TRADE) && !r_phase) begin
                        r_phase <= 1'b1;
                        r_id    <= r_other;
                        r_sidx  <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_SSCAN;
                    end else begin
                        r_state <= S_TOP;
                    end
                end
                S_TOP: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid      <= 1'b1;
                        r_res.status     <= r_status;
                        r_res.bid_valid  <= (r_bid_used != '0);
                        r_res.bid_px     <= (r_bid_used != '0) ? bq.price : '0;
                        r_res.bid_volume <= (r_bid_used != '0) ? bq.total : '0;
                        r_res.bid_orders <= (r_bid_used != '0) ? bq.count : '0;
                        r_res.ask_valid  <= (r_ask_used != '0);
                        r_res.ask_px     <= (r_ask_used != '0) ? aq.price : '0;
                        r_res.ask_volume <= (r_ask_used != '0) ? aq.total : '0;
                        r_res.ask_orders <= (r_ask_used != '0) ? aq.count : '0;
                        r_res.bid_used   <= USED_W'(r_bid_used);
                        r_res.ask_used   <= USED_W'(r_ask_used);
                        r_res.live       <= LIVE_W'(r_live);
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/price_level_order_book.sv
`timescale 1ns / 1ps
// channel  | valid       | stall        | payload
// request  | i_in_valid  | o_in_stall   | i_kind .. i_quantity
// result   | o_out_valid | i_out_stall  | o_status .. o_live_orders
//
// one request at a time, the time taken grows with each slot and level searched
// the order table is searched one slot per cycle and the level table one level per cycle
// a level shift reads then writes each level, a trade runs the search twice
// after reset the order table is cleared slot by slot, requests stall
// a two-deep queue takes requests while the previous result waits to be taken
module price_level_order_book #(
    parameter int MAX_ORDERS = 1024,
    parameter int LEVEL_CAP  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [47:0] i_order_id,
    input  logic [47:0] i_other_order_id,
    input  logic        i_side,
    input  logic [31:0] i_price_ticks,
    input  logic [31:0] i_quantity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_bid_valid,
    output logic [31:0] o_best_bid_price,
    output logic [47:0] o_best_bid_volume,
    output logic [10:0] o_best_bid_orders,
    output logic        o_ask_valid,
    output logic [31:0] o_best_ask_price,
    output logic [47:0] o_best_ask_volume,
    output logic [10:0] o_best_ask_orders,
    output logic [6:0]  o_bid_levels_used,
    output logic [6:0]  o_ask_levels_used,
    output logic [10:0] o_live_orders
);
    import plob_pkg::*;

    logic ready;
    logic req_valid;
    logic req_pop;
    t_req req;
    t_res res;

    plob_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (ready),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_kind           (i_kind),
        .i_order_id       (i_order_id),
        .i_other_order_id (i_other_order_id),
        .i_side           (i_side),
        .i_price_ticks    (i_price_ticks),
        .i_quantity       (i_quantity),
        .o_req_valid      (req_valid),
        .i_req_pop        (req_pop),
        .o_req            (req)
    );

    plob_back #(.MAX_ORDERS(MAX_ORDERS), .LEVEL_CAP(LEVEL_CAP)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_ready     (ready),
        .i_req_valid (req_valid),
        .o_req_pop   (req_pop),
        .i_req       (req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res)
    );

    assign o_status          = res.status;
    assign o_bid_valid       = res.bid_valid;
    assign o_best_bid_price  = res.bid_px;
    assign o_best_bid_volume = res.bid_volume;
    assign o_best_bid_orders = res.bid_orders;
    assign o_ask_valid       = res.ask_valid;
    assign o_best_ask_price  = res.ask_px;
    assign o_best_ask_volume = res.ask_volume;
    assign o_best_ask_orders = res.ask_orders;
    assign o_bid_levels_used = res.bid_used;
    assign o_ask_levels_used = res.ask_used;
    assign o_live_orders     = res.live;
endmodule
